[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL of the console writer.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge while reset is released.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Checks that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/tcdw_pkg.sv]
// Package of the text console decimal writer: screen geometry, codes and types.
// Depends on nothing; used by text_console_decimal_writer_core.
package tcdw_pkg;

    localparam int COLUMNS      = 80;
    localparam int SCREEN_CELLS = 2000;

    localparam int CURSOR_W = 11;
    localparam int COL_W    = 8;
    localparam int CHAR_W   = 8;
    localparam int ATTR_W   = 8;
    localparam int WORD_W   = 16;
    localparam int NUM_W    = 32;
    localparam int DIGITS   = 10;
    localparam int BCD_W    = DIGITS * 4;
    localparam int BITCNT_W = 5;
    localparam int DIGCNT_W = 4;

    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h07;
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] DIGIT_ZERO   = 8'd48;

    localparam logic OP_CHAR   = 1'b0;
    localparam logic OP_NUMBER = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHAR,
        ST_CONVERT,
        ST_EMIT
    } t_state;

endpackage

[rtl/core/text_console_decimal_writer_core.sv]
// Top level of the text console decimal writer: cursor, decimal conversion and
// cell write output. Depends on tcdw_pkg and assert_macros.svh.
//
// The block takes one transaction at a time on the input channel. A character
// transaction writes one cell at the cursor and advances it; a newline writes
// nothing and moves the cursor to the start of the next row, wrapping to the
// top left cell past the end of the screen. A number transaction is converted
// to decimal by a shift-and-add-three converter that takes one bit of the
// number per clock. The ten BCD digits are then shifted out most significant
// first, one digit per cycle while the output register can take a cell, with
// leading zeros skipped silently and one cell write per remaining digit; o_last
// marks the final cell of each transaction that writes cells. The cell writes
// sit in an output register, so the block keeps converting and accepting input
// while a finished cell waits to be taken; it stalls only when it has a further
// cell to write. The attribute register (reset 0x07) may be written only while
// the block is idle.
module text_console_decimal_writer_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Attribute register write port.
    input  logic                          i_attr_we,
    input  logic [tcdw_pkg::ATTR_W-1:0]   i_attr_data,
    // Input channel.
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_operation,
    input  logic [tcdw_pkg::CHAR_W-1:0]   i_character,
    input  logic [tcdw_pkg::NUM_W-1:0]    i_number,
    // Output channel of cell writes.
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [tcdw_pkg::CURSOR_W-1:0] o_cell_index,
    output logic [tcdw_pkg::WORD_W-1:0]   o_cell_word,
    output logic                          o_last
);

    `include "assert_macros.svh"

    // Control state.
    tcdw_pkg::t_state r_state, n_state;
    logic [tcdw_pkg::CURSOR_W-1:0] r_cursor, n_cursor;
    logic [tcdw_pkg::COL_W-1:0]    r_col, n_col;
    logic [tcdw_pkg::ATTR_W-1:0]   r_attr, n_attr;
    logic                          r_out_valid, n_out_valid;
    logic [tcdw_pkg::BITCNT_W-1:0] r_bitcnt, n_bitcnt;
    logic [tcdw_pkg::DIGCNT_W-1:0] r_digcnt, n_digcnt;
    logic                          r_started, n_started;

    // Datapath registers.
    logic [tcdw_pkg::CHAR_W-1:0]   r_char, n_char;
    logic [tcdw_pkg::NUM_W-1:0]    r_bin, n_bin;
    logic [tcdw_pkg::BCD_W-1:0]    r_bcd, n_bcd;
    logic [tcdw_pkg::CURSOR_W-1:0] r_cell_index, n_cell_index;
    logic [tcdw_pkg::WORD_W-1:0]   r_cell_word, n_cell_word;
    logic                          r_last, n_last;

    logic                          w_in_acc;
    logic                          w_slot;
    logic [tcdw_pkg::BCD_W-1:0]    w_bcd_adj;
    logic [3:0]                    w_digit;
    logic [tcdw_pkg::CURSOR_W-1:0] w_adv_cursor;
    logic [tcdw_pkg::COL_W-1:0]    w_adv_col;
    logic [tcdw_pkg::CURSOR_W-1:0] w_row_start;
    logic [tcdw_pkg::CURSOR_W:0]   w_nl_sum;
    logic [tcdw_pkg::CURSOR_W-1:0] w_nl_cursor;

    assign o_in_ready   = (r_state == tcdw_pkg::ST_IDLE);
    assign w_in_acc     = i_in_valid && o_in_ready;
    // The output register can take a new cell when it is empty or being drained.
    assign w_slot       = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_cell_index = r_cell_index;
    assign o_cell_word  = r_cell_word;
    assign o_last       = r_last;

    // Cursor after one cell write. The column counter tracks the cursor modulo
    // the row length, so a newline needs no division.
    always_comb begin
        if (32'(r_cursor) + 32'd1 >= 32'(tcdw_pkg::SCREEN_CELLS)) begin
            w_adv_cursor = '0;
            w_adv_col    = '0;
        end else begin
            w_adv_cursor = r_cursor + tcdw_pkg::CURSOR_W'(1);
            if (32'(r_col) + 32'd1 >= 32'(tcdw_pkg::COLUMNS)) begin
                w_adv_col = '0;
            end else begin
                w_adv_col = r_col + tcdw_pkg::COL_W'(1);
            end
        end
    end

    // Cursor after a newline: start of the current row plus one row.
    assign w_row_start = r_cursor - tcdw_pkg::CURSOR_W'(r_col);
    assign w_nl_sum    = {1'b0, w_row_start} + (tcdw_pkg::CURSOR_W+1)'(tcdw_pkg::COLUMNS);
    assign w_nl_cursor = (32'(w_nl_sum) >= 32'(tcdw_pkg::SCREEN_CELLS)) ?
                         '0 : w_nl_sum[tcdw_pkg::CURSOR_W-1:0];

    // Add-three correction of every BCD digit ahead of the next shift.
    always_comb begin
        for (int d = 0; d < tcdw_pkg::DIGITS; d++) begin
            if (r_bcd[d*4 +: 4] >= 4'd5) begin
                w_bcd_adj[d*4 +: 4] = r_bcd[d*4 +: 4] + 4'd3;
            end else begin
                w_bcd_adj[d*4 +: 4] = r_bcd[d*4 +: 4];
            end
        end
    end

    // The digit to print is always the top nibble of the BCD shift register.
    assign w_digit = r_bcd[tcdw_pkg::BCD_W-1 -: 4];

    always_comb begin
        n_state      = r_state;
        n_cursor     = r_cursor;
        n_col        = r_col;
        n_attr       = r_attr;
        n_out_valid  = r_out_valid;
        n_bitcnt     = r_bitcnt;
        n_digcnt     = r_digcnt;
        n_started    = r_started;
        n_char       = r_char;
        n_bin        = r_bin;
        n_bcd        = r_bcd;
        n_cell_index = r_cell_index;
        n_cell_word  = r_cell_word;
        n_last       = r_last;

        if (i_attr_we) begin
            n_attr = i_attr_data;
        end
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            tcdw_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_operation == tcdw_pkg::OP_NUMBER) begin
                        n_bin    = i_number;
                        n_bcd    = '0;
                        n_bitcnt = '0;
                        n_state  = tcdw_pkg::ST_CONVERT;
                    end else if (i_character == tcdw_pkg::NEWLINE_CODE) begin
                        n_cursor = w_nl_cursor;
                        n_col    = '0;
                    end else begin
                        n_char  = i_character;
                        n_state = tcdw_pkg::ST_CHAR;
                    end
                end
            end
            tcdw_pkg::ST_CHAR: begin
                if (w_slot) begin
                    n_out_valid  = 1'b1;
                    n_cell_index = r_cursor;
                    n_cell_word  = {r_attr, r_char};
                    n_last       = 1'b1;
                    n_cursor     = w_adv_cursor;
                    n_col        = w_adv_col;
                    n_state      = tcdw_pkg::ST_IDLE;
                end
            end
            tcdw_pkg::ST_CONVERT: begin
                // One bit of the number moves into the BCD register per cycle.
                n_bcd    = {w_bcd_adj[tcdw_pkg::BCD_W-2:0], r_bin[tcdw_pkg::NUM_W-1]};
                n_bin    = {r_bin[tcdw_pkg::NUM_W-2:0], 1'b0};
                n_bitcnt = r_bitcnt + tcdw_pkg::BITCNT_W'(1);
                if (r_bitcnt == tcdw_pkg::BITCNT_W'(tcdw_pkg::NUM_W - 1)) begin
                    n_digcnt  = tcdw_pkg::DIGCNT_W'(tcdw_pkg::DIGITS - 1);
                    n_started = 1'b0;
                    n_state   = tcdw_pkg::ST_EMIT;
                end
            end
            tcdw_pkg::ST_EMIT: begin
                if (w_digit == 4'd0 && !r_started && r_digcnt != '0) begin
                    // Leading zero: drop it without a cell write.
                    n_bcd    = {r_bcd[tcdw_pkg::BCD_W-5:0], 4'd0};
                    n_digcnt = r_digcnt - tcdw_pkg::DIGCNT_W'(1);
                end else if (w_slot) begin
                    n_out_valid  = 1'b1;
                    n_cell_index = r_cursor;
                    n_cell_word  = {r_attr, tcdw_pkg::DIGIT_ZERO + tcdw_pkg::CHAR_W'(w_digit)};
                    n_last       = (r_digcnt == '0);
                    n_cursor     = w_adv_cursor;
                    n_col        = w_adv_col;
                    n_started    = 1'b1;
                    n_bcd        = {r_bcd[tcdw_pkg::BCD_W-5:0], 4'd0};
                    n_digcnt     = r_digcnt - tcdw_pkg::DIGCNT_W'(1);
                    if (r_digcnt == '0) begin
                        n_state = tcdw_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = tcdw_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tcdw_pkg::ST_IDLE;
            r_cursor    <= '0;
            r_col       <= '0;
            r_attr      <= tcdw_pkg::ATTR_RESET;
            r_out_valid <= 1'b0;
            r_bitcnt    <= '0;
            r_digcnt    <= '0;
            r_started   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cursor    <= n_cursor;
            r_col       <= n_col;
            r_attr      <= n_attr;
            r_out_valid <= n_out_valid;
            r_bitcnt    <= n_bitcnt;
            r_digcnt    <= n_digcnt;
            r_started   <= n_started;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char       <= n_char;
        r_bin        <= n_bin;
        r_bcd        <= n_bcd;
        r_cell_index <= n_cell_index;
        r_cell_word  <= n_cell_word;
        r_last       <= n_last;
    end

    // The cursor and its column never leave the screen.
    `ASSERT_CLK(a_cursor_range, i_clk, i_rst_n,
        (32'(r_cursor) < 32'(tcdw_pkg::SCREEN_CELLS)) && (32'(r_col) < 32'(tcdw_pkg::COLUMNS)),
        "cursor or column out of range")
    // A number transaction always occupies the block in the next cycle.
    `ASSERT_NEXT(a_number_busy, i_clk, i_rst_n,
        w_in_acc && (i_operation == tcdw_pkg::OP_NUMBER),
        !o_in_ready && (r_state == tcdw_pkg::ST_CONVERT),
        "number transaction did not start conversion")
    // The final digit of a number returns the block to idle with last set.
    `ASSERT_NEXT(a_last_digit, i_clk, i_rst_n,
        (r_state == tcdw_pkg::ST_EMIT) && w_slot && (r_digcnt == '0),
        o_in_ready && o_out_valid && o_last,
        "final digit did not close the transaction")

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps
// Testbench of text_console_decimal_writer_core: directed and random console traffic,
// every cell write checked against a cursor and decimal-digit predictor.
// Depends on tcdw_pkg and the core RTL only.
module tb_top;

    // One console request, with an optional hand-typed cell write for rows whose
    // single result can be read off directly.
    typedef struct packed {
        logic                          op;
        logic [tcdw_pkg::CHAR_W-1:0]   ch;
        logic [tcdw_pkg::NUM_W-1:0]    num;
        logic                          pinned;
        logic [tcdw_pkg::CURSOR_W-1:0] pin_idx;
        logic [tcdw_pkg::WORD_W-1:0]   pin_word;
    } t_row;

    // One cell write as seen on the output channel.
    typedef struct packed {
        logic [tcdw_pkg::CURSOR_W-1:0] idx;
        logic [tcdw_pkg::WORD_W-1:0]   word;
        logic                          last;
    } t_cell;

    localparam int PLAN_ROWS = 24;
    // A number keeps the core busy through its conversion and digits; a newline leaves
    // no result behind, so this many cycles are allowed after the last cell before the
    // core counts as idle.
    localparam int SETTLE_CYCLES = 60;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 32;
    // The receiver holds off once this many transactions have gone in, which falls
    // among the long numbers that the first random phase runs across the end of
    // the screen.
    localparam int HOLD_AFTER = 48;

    // Directed rows. The cursor walk of the pinned rows: 0, 1, 2, 3, then two
    // newlines take it to 160, and the ten digits of 4294967295 end at 171.
    localparam t_row PLAN [PLAN_ROWS] = '{
        '{tcdw_pkg::OP_CHAR,   8'h41, 32'h0000_0000, 1'b1, 11'd0,   16'h0741},
        '{tcdw_pkg::OP_NUMBER, 8'h00, 32'h0000_0000, 1'b1, 11'd1,   16'h0730},
        '{tcdw_pkg::OP_CHAR,   8'h00, 32'h0000_0000, 1'b1, 11'd2,   16'h0700},
        '{tcdw_pkg::OP_CHAR,   8'hFF, 32'h0000_0000, 1'b1, 11'd3,   16'h07FF},
        '{tcdw_pkg::OP_CHAR,   tcdw_pkg::NEWLINE_CODE, 32'hFFFF_FFFF, 1'b0, 11'd0, 16'h0000},
        '{tcdw_pkg::OP_CHAR,   tcdw_pkg::NEWLINE_CODE, 32'h0000_0000, 1'b0, 11'd0, 16'h0000},
        '{tcdw_pkg::OP_CHAR,   8'h0D, 32'h0000_0000, 1'b1, 11'd160, 16'h070D},
        '{tcdw_pkg::OP_CHAR,   8'h09, 32'h0000_0000, 1'b0, 11'd0,   16'h0000},
        '{tcdw_pkg::OP_NUMBER, 8'h00, 32'hFFFF_FFFF, 1'b0, 11'd0,   16'h0000},
        '{tcdw_pkg::OP_NUMBER, 8'h5A, 32'h0000_0001, 1'b1, 11'd172, 16'h0731},
        '{tcdw_pkg::OP_NUMBER, 8'hFF, 32'h0000_0009, 1'b1, 11'd173, 16'h0739},
        '{tcdw_pkg::OP_NUMBER, 8'h00, 32'd10,        1'b0, 11'd0,   16'h0000},
        '{tcdw_pkg::OP_NUMBER, 8'h00, 32'd99,        1'b0, 11'd0,   16'h0000},
        '{tcdw_pkg::OP_NUMBER, 8'h00, 32'd100,       1'b0, 11'd0,   16'h0000},
        '{tcdw_pkg::OP_NUMBER, 8'h00, 32'd999999999, 1'b0, 11'd0,   16'h0000},
        '{tcdw_pkg::OP_NUMBER, 8'h00, 32'd1000000000, 1'b0, 11'd0,  16'h0000},
        '{tcdw_pkg::OP_NUMBER, 8'h00, 32'h8000_0000, 1'b0, 11'd0,   16'h0000},
        '{tcdw_pkg::OP_NUMBER, 8'h00, 32'h7FFF_FFFF, 1'b0, 11'd0,   16'h0000},
        '{tcdw_pkg::OP_CHAR,   8'h7E, 32'hFFFF_FFFF, 1'b0, 11'd0,   16'h0000},
        '{tcdw_pkg::OP_CHAR,   8'h0B, 32'h0000_0000, 1'b0, 11'd0,   16'h0000},
        '{tcdw_pkg::OP_CHAR,   tcdw_pkg::NEWLINE_CODE, 32'h0000_0000, 1'b0, 11'd0, 16'h0000},
        '{tcdw_pkg::OP_NUMBER, tcdw_pkg::NEWLINE_CODE, 32'h0000_0000, 1'b0, 11'd0, 16'h0000},
        '{tcdw_pkg::OP_CHAR,   8'h80, 32'h0000_0000, 1'b0, 11'd0,   16'h0000},
        '{tcdw_pkg::OP_NUMBER, 8'h00, 32'd4294967290, 1'b0, 11'd0,  16'h0000}
    };

    logic                          i_clk;
    logic                          i_rst_n      = 1'b0;
    logic                          i_attr_we    = 1'b0;
    logic [tcdw_pkg::ATTR_W-1:0]   i_attr_data  = '0;
    logic                          i_in_valid   = 1'b0;
    logic                          o_in_ready;
    logic                          i_operation  = tcdw_pkg::OP_CHAR;
    logic [tcdw_pkg::CHAR_W-1:0]   i_character  = '0;
    logic [tcdw_pkg::NUM_W-1:0]    i_number     = '0;
    logic                          o_out_valid;
    logic                          i_out_ready  = 1'b0;
    logic [tcdw_pkg::CURSOR_W-1:0] o_cell_index;
    logic [tcdw_pkg::WORD_W-1:0]   o_cell_word;
    logic                          o_last;

    // Hand-typed expectation that travels with the transaction on the input.
    logic                          drv_pinned   = 1'b0;
    t_cell                         drv_pin_cell = '0;

    // Predictor state: the screen cursor and attribute as the core should hold them.
    logic [tcdw_pkg::CURSOR_W-1:0] model_cursor = '0;
    logic [tcdw_pkg::ATTR_W-1:0]   model_attr   = tcdw_pkg::ATTR_RESET;
    t_cell                         cells_due[$];

    int                            errors       = 0;
    int                            items_sent   = 0;
    int unsigned                   tick         = 0;
    bit                            hold_done    = 1'b0;
    logic                          calm;

    text_console_decimal_writer_core i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_attr_we    (i_attr_we),
        .i_attr_data  (i_attr_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_operation  (i_operation),
        .i_character  (i_character),
        .i_number     (i_number),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_cell_index (o_cell_index),
        .o_cell_word  (o_cell_word),
        .o_last       (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Both sides run without random idling while calm is set at the start of each tick window.
    always @(posedge i_clk) begin
        tick <= tick + 1;
    end
    assign calm = (tick % 3000) < 700;

    // The cursor moves one cell forward and wraps to the top left cell at the
    // end of the screen.
    function automatic void step_cursor();
        if (model_cursor == tcdw_pkg::CURSOR_W'(tcdw_pkg::SCREEN_CELLS - 1)) begin
            model_cursor = '0;
        end else begin
            model_cursor = model_cursor + tcdw_pkg::CURSOR_W'(1);
        end
    endfunction

    function automatic void put_cell(input logic [tcdw_pkg::CHAR_W-1:0] code,
                                     input logic is_last);
        t_cell c;
        c.idx  = model_cursor;
        c.word = {model_attr, code};
        c.last = is_last;
        cells_due.push_back(c);
        step_cursor();
    endfunction

    // Works out the cell writes that one console request causes.
    function automatic void predict_cells(input logic op,
                                          input logic [tcdw_pkg::CHAR_W-1:0] ch,
                                          input logic [tcdw_pkg::NUM_W-1:0] num);
        logic [3:0]                 digit [tcdw_pkg::DIGITS];
        logic [tcdw_pkg::NUM_W-1:0] rest;
        int                         n;
        int                         next_row;
        if (op == tcdw_pkg::OP_CHAR) begin
            if (ch == tcdw_pkg::NEWLINE_CODE) begin
                // A newline writes nothing; past the bottom row it wraps to the top.
                next_row = (int'(model_cursor) / tcdw_pkg::COLUMNS + 1) * tcdw_pkg::COLUMNS;
                model_cursor = (next_row >= tcdw_pkg::SCREEN_CELLS) ?
                               '0 : tcdw_pkg::CURSOR_W'(next_row);
            end else begin
                put_cell(ch, 1'b1);
            end
        end else begin
            // Peel off decimal digits least significant first; zero still gives one.
            rest = num;
            n = 0;
            do begin
                digit[n] = 4'(rest % 10);
                rest = rest / 10;
                n++;
            end while (rest != 0);
            for (int k = n - 1; k >= 0; k--) begin
                put_cell(tcdw_pkg::DIGIT_ZERO + tcdw_pkg::CHAR_W'(digit[k]), k == 0);
            end
        end
    endfunction

    function automatic void check_field(input string what, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
            errors++;
        end
    endfunction

    // Watches both channels. The request side runs first so that expectations
    // exist before any cell write that could follow them.
    always @(posedge i_clk) begin
        t_cell want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                predict_cells(i_operation, i_character, i_number);
                if (drv_pinned) begin
                    void'(cells_due.pop_back());
                    cells_due.push_back(drv_pin_cell);
                end
            end
            if (o_out_valid && i_out_ready) begin
                if (cells_due.size() == 0) begin
                    $display("%0t: cell write with none expected, index %0d word 0x%04h",
                             $time, o_cell_index, o_cell_word);
                    errors++;
                end else begin
                    want = cells_due.pop_front();
                    check_field("cell_index", 32'(want.idx), 32'(o_cell_index));
                    check_field("cell_word", 32'(want.word), 32'(o_cell_word));
                    check_field("last", 32'(want.last), 32'(o_last));
                end
            end
        end
    end

    // Offers one transaction after a random gap and holds it until it is taken.
    task automatic send_item(input t_row r);
        while (!calm && $urandom_range(99) < 16) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_operation  <= r.op;
        i_character  <= r.ch;
        i_number     <= r.num;
        drv_pinned   <= r.pinned;
        drv_pin_cell <= '{r.pin_idx, r.pin_word, 1'b1};
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    // Stops offering, lets every expected cell arrive and then lets a trailing
    // newline or a last conversion finish.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (cells_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_attribute(input logic [tcdw_pkg::ATTR_W-1:0] value);
        drain();
        i_attr_we   <= 1'b1;
        i_attr_data <= value;
        @(posedge i_clk);
        i_attr_we   <= 1'b0;
        model_attr  = value;
    endtask

    // Numbers of every length, with zero, the largest value and the edges of each
    // power of ten turning up often.
    function automatic logic [tcdw_pkg::NUM_W-1:0] pick_number();
        logic [tcdw_pkg::NUM_W-1:0] p;
        p = 1;
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: begin
                repeat ($urandom_range(9, 1)) p = p * 10;
                return p - $urandom_range(1);
            end
            default: return $urandom() >> $urandom_range(31);
        endcase
    endfunction

    // Well-formed text uses printable characters; noise may be any code at all.
    function automatic t_row pick_item(input bit noisy);
        t_row r;
        r     = '0;
        r.op  = 1'($urandom_range(1));
        r.ch  = tcdw_pkg::CHAR_W'($urandom());
        r.num = $urandom();
        if (!noisy) begin
            if (r.op == tcdw_pkg::OP_CHAR) begin
                r.ch = tcdw_pkg::CHAR_W'($urandom_range(8'h7E, 8'h20));
            end else begin
                r.num = pick_number();
            end
        end
        return r;
    endfunction

    // One random phase under a fresh attribute. It first drives the cursor down to
    // the bottom row, then either wraps it with one more newline or runs a line of
    // digits across the last cell of the screen, then sends lines of text and noise.
    task automatic run_phase(input logic [tcdw_pkg::ATTR_W-1:0] attr,
                             input bit wrap_by_newline);
        t_row r;
        int   stop_at;
        set_attribute(attr);
        stop_at = items_sent + PHASE_ITEMS;
        r    = '0;
        r.op = tcdw_pkg::OP_CHAR;
        r.ch = tcdw_pkg::NEWLINE_CODE;
        repeat (tcdw_pkg::SCREEN_CELLS / tcdw_pkg::COLUMNS - 1
                - int'(model_cursor) / tcdw_pkg::COLUMNS + wrap_by_newline)
        begin
            r.num = $urandom();
            send_item(r);
        end
        if (!wrap_by_newline) begin
            r.ch = tcdw_pkg::CHAR_W'($urandom_range(8'h7E, 8'h20));
            send_item(r);
            r.op = tcdw_pkg::OP_NUMBER;
            repeat (8) begin
                r.num = $urandom_range(32'hFFFF_FFFF, 32'd1_000_000_000);
                send_item(r);
            end
        end
        while (items_sent < stop_at) begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: begin
                    repeat ($urandom_range(6, 1)) send_item(pick_item(1'b0));
                    r     = '0;
                    r.op  = tcdw_pkg::OP_CHAR;
                    r.ch  = tcdw_pkg::NEWLINE_CODE;
                    r.num = $urandom();
                    send_item(r);
                end
                default: repeat ($urandom_range(4, 1)) send_item(pick_item(1'b1));
            endcase
        end
    endtask

    // Receiver: stalls at random, and once, while long numbers are going in, refuses
    // cell writes for a long stretch so that the core backs up onto its input.
    initial begin
        forever begin
            @(posedge i_clk);
            if (!hold_done && items_sent >= HOLD_AFTER) begin
                hold_done = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_out_ready <= calm || ($urandom_range(99) >= 16);
            end
        end
    end

    // Stimulus: reset, the directed rows under the reset attribute, then three
    // random phases that take the attribute to all ones, all zeros and a random value.
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (PLAN[i]) send_item(PLAN[i]);
        run_phase(8'hFF, 1'b0);
        run_phase(8'h00, 1'b1);
        run_phase(tcdw_pkg::ATTR_W'($urandom_range(255)), 1'b0);
        drain();
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #1_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
